### rtl/mcbp_pkg.sv
// ----------------------------------------------------------------------------
// mcbp_pkg
// Shared types and constants for the barrier path monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package mcbp_pkg;

    // one input request: a normal draw and the end-of-path marker
    typedef struct packed {
        logic signed [15:0] normal_sample;
        logic               last_step;
    } t_in_item;

    // one result request
    typedef struct packed {
        logic [31:0] path_payoff;
        logic [63:0] payoff_total;
        logic [63:0] payoff_square_total;
        logic [31:0] paths_done;
    } t_out_item;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SPOT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIKE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BARRIER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ANTI      = 3'd6;

    // output shift of the multiplier
    localparam logic [1:0] SH_NONE = 2'd0;
    localparam logic [1:0] SH_28   = 2'd1;
    localparam logic [1:0] SH_56   = 2'd2;

    localparam logic [63:0] ONE_Q56   = 64'h0100_0000_0000_0000;
    localparam logic [3:0]  TERMS     = 4'd10;
    localparam logic [2:0]  LAST_SQ   = 3'd5;

    typedef struct packed {
        logic        start;
        logic [1:0]  shift_sel;
        logic [63:0] op_a;
        logic [63:0] op_b;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_mul_rsp;

endpackage

`default_nettype wire

### rtl/mcbp_mul.sv
// ----------------------------------------------------------------------------
// mcbp_mul
// 64x64 multiply with round-half-up right shift and saturation, built on one
// 32x32 multiplier that forms the four partial products in turn, then a rounding step.
// ----------------------------------------------------------------------------
`default_nettype none

module mcbp_mul (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mcbp_pkg::t_mul_req  i_req,
    output mcbp_pkg::t_mul_rsp  o_rsp
);
    import mcbp_pkg::*;

    logic [63:0]  r_a, r_b;
    logic [1:0]   r_sh;
    logic [127:0] r_acc, n_acc;
    logic [1:0]   r_idx;
    logic         r_busy, r_rnd, r_done;
    logic [63:0]  r_res, n_res;

    logic [31:0]  a_part, b_part;
    logic [63:0]  pp;
    logic [6:0]   shamt;
    logic [127:0] rounded;

    assign a_part = r_idx[0] ? r_a[63:32] : r_a[31:0];
    assign b_part = r_idx[1] ? r_b[63:32] : r_b[31:0];
    assign pp     = a_part * b_part;
    assign shamt  = {r_idx[0] & r_idx[1], r_idx[0] ^ r_idx[1], 5'd0};
    assign n_acc  = r_acc + ({64'd0, pp} << shamt);

    always_comb begin
        rounded = r_acc;
        n_res   = r_acc[63:0];
        unique case (r_sh)
            SH_28: begin
                rounded = r_acc + (128'd1 << 27);
                n_res   = (rounded[127:92] != 36'd0) ? '1 : rounded[91:28];
            end
            SH_56: begin
                rounded = r_acc + (128'd1 << 55);
                n_res   = (rounded[127:120] != 8'd0) ? '1 : rounded[119:56];
            end
            default: begin
                n_res = r_acc[63:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rnd  <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy && !r_rnd) begin
                r_a    <= i_req.op_a;
                r_b    <= i_req.op_b;
                r_sh   <= i_req.shift_sel;
                r_acc  <= 128'd0;
                r_idx  <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_idx <= r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    r_busy <= 1'b0;
                    r_rnd  <= 1'b1;
                end
            end else if (r_rnd) begin
                r_res  <= n_res;
                r_done <= 1'b1;
                r_rnd  <= 1'b0;
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

`default_nettype wire

### rtl/mc_barrier_path_monitor.sv
// ----------------------------------------------------------------------------
// mc_barrier_path_monitor
// Monte Carlo barrier option path monitor, geometric Brownian motion, fixed
// point, one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Each accepted request carries one normal draw and advances the price path
// and its mirrored path by one step; on a request marked last_step one result
// request is produced with the path payoff and the running sums. Every pass
// through the shared 64x64 multiplier runs through issue, four 32x32 partial
// products, rounding and handoff. Per path, exp() is a Taylor series to the
// tenth power, each term one multiplier pass plus a restoring divide by the
// term index and an accumulate step, then six squarings and the price
// multiply. Both paths are always advanced, after the diffusion product, and
// the input stays not ready until both are done, so a new request is taken
// only once the last one is through. A last step also adds the payoff, its
// square and the result load before the input is ready again.
// A finished result waits in the output register while the next request is
// taken; a new result stalls only if the previous one has still not left.
// ----------------------------------------------------------------------------
`default_nettype none

module mc_barrier_path_monitor #(
    parameter int unsigned PRICE_WIDTH = 32
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  mcbp_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output mcbp_pkg::t_out_item                   o_out_data,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [mcbp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [31:0]                            i_cfg_data
);
    import mcbp_pkg::*;

    localparam int unsigned PW = PRICE_WIDTH;

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ZMUL  = 4'd1;
    localparam logic [3:0] S_MWAIT = 4'd2;
    localparam logic [3:0] S_ZCAP  = 4'd3;
    localparam logic [3:0] S_XSET  = 4'd4;
    localparam logic [3:0] S_TMUL  = 4'd5;
    localparam logic [3:0] S_DIVS  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_TACC  = 4'd8;
    localparam logic [3:0] S_SQ    = 4'd9;
    localparam logic [3:0] S_SQW   = 4'd10;
    localparam logic [3:0] S_PMUL  = 4'd11;
    localparam logic [3:0] S_PUPD  = 4'd12;
    localparam logic [3:0] S_PAY   = 4'd13;
    localparam logic [3:0] S_PSQ   = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    // configuration registers
    logic [31:0] r_spot, r_strike, r_barrier;
    logic signed [31:0] r_drift;
    logic [30:0] r_diff;
    logic [2:0]  r_mode;
    logic        r_anti;

    // path state
    logic [PW-1:0] r_price_p, r_price_m;
    logic          r_crossed_p, r_crossed_m, r_path_open;
    logic [63:0]   r_psum, r_qsum;
    logic [31:0]   r_count;

    // working registers
    logic [3:0]          r_state, r_after;
    logic signed [15:0]  r_z;
    logic                r_last;
    logic                r_path;      // 0 main path, 1 mirrored path
    logic [46:0]         r_zprod;     // |diffusion * z|
    logic                r_neg;
    logic [63:0]         r_mag, r_sum, r_term, r_dvd;
    logic [3:0]          r_k, r_rem;
    logic [3:0]          r_dcnt;
    logic [2:0]          r_sqc;
    logic [31:0]         r_pay;
    logic                r_out_valid;
    t_out_item           r_out;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    mcbp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    function automatic logic crosses(input logic [63:0] p, input logic [31:0] bar,
                                     input logic down);
        logic [63:0] b64;
        b64 = {32'd0, bar};
        return down ? (p <= b64) : (p >= b64);
    endfunction

    function automatic logic [63:0] leg_value(input logic [63:0] p, input logic crossed,
                                              input logic [2:0] mode,
                                              input logic [31:0] strike);
        logic [63:0] k64;
        logic        alive;
        k64   = {32'd0, strike};
        alive = mode[2] ? crossed : !crossed;
        if (!alive) begin
            return 64'd0;
        end else if (mode[0]) begin
            return (k64 > p) ? k64 - p : 64'd0;
        end
        return (p > k64) ? p - k64 : 64'd0;
    endfunction

    // spot clamped to the price width
    logic [63:0]   spot64;
    logic [PW-1:0] s0;
    assign spot64 = {32'd0, r_spot};
    assign s0     = ((spot64 >> PW) != 64'd0) ? '1 : spot64[PW-1:0];

    // exponent for the current path
    logic               z_neg;
    logic signed [47:0] prod_s, t_s;
    logic signed [49:0] x_wide;
    logic signed [30:0] x_c;
    logic [30:0]        x_abs;
    always_comb begin
        z_neg  = r_path ? (r_z > 16'sd0) : (r_z < 16'sd0);
        prod_s = z_neg ? -$signed({1'b0, r_zprod}) : $signed({1'b0, r_zprod});
        t_s    = (prod_s + 48'sd2048) >>> 12;
        x_wide = 50'(r_drift) + 50'(t_s);
        if (x_wide < -50'sd1073741824) begin
            x_c = -31'sd1073741824;
        end else if (x_wide > 50'sd1073741823) begin
            x_c = 31'sd1073741823;
        end else begin
            x_c = x_wide[30:0];
        end
        x_abs = x_c[30] ? 31'(-x_c) : 31'(x_c);
    end

    // four restoring steps of the divide by the term index
    logic [3:0] d_rem, d_q;
    logic [4:0] d_try;
    always_comb begin
        d_rem = r_rem;
        d_q   = 4'd0;
        d_try = 5'd0;
        for (int i = 0; i < 4; i++) begin
            d_try = {d_rem, r_dvd[63-i]};
            if (d_try >= {1'b0, r_k}) begin
                d_rem      = 4'(d_try - {1'b0, r_k});
                d_q[3-i]   = 1'b1;
            end else begin
                d_rem      = d_try[3:0];
            end
        end
    end

    // price update and payoff
    logic [PW-1:0] cur_price;
    logic [63:0]   cur_price64, factor, np_clamp64;
    logic [PW-1:0] np;
    logic [64:0]   pay_sum;
    logic [63:0]   pay_wide;
    logic [31:0]   pay32;
    logic [64:0]   psum_n, qsum_n;
    always_comb begin
        cur_price   = r_path ? r_price_m : r_price_p;
        cur_price64 = {{(64-PW){1'b0}}, cur_price};
        factor      = (r_sum + (64'd1 << 27)) >> 28;
        np          = (mul_rsp.result[63:PW] != '0) ? '1 : mul_rsp.result[PW-1:0];
        np_clamp64  = {{(64-PW){1'b0}}, np};
        pay_sum = {1'b0, leg_value({{(64-PW){1'b0}}, r_price_p}, r_crossed_p, r_mode,
                                   r_strike)}
                + {1'b0, leg_value({{(64-PW){1'b0}}, r_price_m}, r_crossed_m, r_mode,
                                   r_strike)};
        pay_wide = r_anti ? pay_sum[64:1]
                 : leg_value({{(64-PW){1'b0}}, r_price_p}, r_crossed_p, r_mode, r_strike);
        pay32    = (pay_wide[63:32] != 32'd0) ? '1 : pay_wide[31:0];
        psum_n   = {1'b0, r_psum} + {33'd0, r_pay};
        qsum_n   = {1'b0, r_qsum} + {1'b0, mul_rsp.result};
    end

    // multiplier requests
    always_comb begin
        mul_req = '0;
        unique case (r_state)
            S_ZMUL: begin
                mul_req.start     = 1'b1;
                mul_req.shift_sel = SH_NONE;
                mul_req.op_a      = {33'd0, r_diff};
                mul_req.op_b      = {47'd0, (r_z < 16'sd0) ? 17'(-17'(r_z)) : 17'(r_z)};
            end
            S_TMUL: begin
                mul_req.start     = 1'b1;
                mul_req.shift_sel = SH_56;
                mul_req.op_a      = r_term;
                mul_req.op_b      = r_mag;
            end
            S_SQ: begin
                mul_req.start     = 1'b1;
                mul_req.shift_sel = SH_56;
                mul_req.op_a      = r_sum;
                mul_req.op_b      = r_sum;
            end
            S_PMUL: begin
                mul_req.start     = 1'b1;
                mul_req.shift_sel = SH_28;
                mul_req.op_a      = cur_price64;
                mul_req.op_b      = factor;
            end
            S_PSQ: begin
                mul_req.start     = 1'b1;
                mul_req.shift_sel = SH_NONE;
                mul_req.op_a      = {32'd0, r_pay};
                mul_req.op_b      = {32'd0, r_pay};
            end
            default: begin
                mul_req = '0;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spot    <= 32'd6553600;
            r_strike  <= 32'd6553600;
            r_barrier <= 32'd7864320;
            r_drift   <= 32'sd0;
            r_diff    <= 31'd0;
            r_mode    <= 3'd0;
            r_anti    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SPOT:      r_spot    <= i_cfg_data;
                REG_STRIKE:    r_strike  <= i_cfg_data;
                REG_BARRIER:   r_barrier <= i_cfg_data;
                REG_DRIFT:     r_drift   <= $signed(i_cfg_data);
                REG_DIFFUSION: r_diff    <= i_cfg_data[30:0];
                REG_MODE:      r_mode    <= i_cfg_data[2:0];
                REG_ANTI:      r_anti    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_price_p   <= '0;
            r_price_m   <= '0;
            r_crossed_p <= 1'b0;
            r_crossed_m <= 1'b0;
            r_path_open <= 1'b0;
            r_psum      <= 64'd0;
            r_qsum      <= 64'd0;
            r_count     <= 32'd0;
            r_out_valid <= 1'b0;
            r_path      <= 1'b0;
        end else begin
            // the final state reloads the output register itself
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_z    <= i_in_data.normal_sample;
                        r_last <= i_in_data.last_step;
                        if (!r_path_open) begin
                            // new path starts at spot, inception is monitored
                            r_price_p   <= s0;
                            r_price_m   <= s0;
                            r_crossed_p <= crosses({{(64-PW){1'b0}}, s0}, r_barrier,
                                                   r_mode[1]);
                            r_crossed_m <= crosses({{(64-PW){1'b0}}, s0}, r_barrier,
                                                   r_mode[1]);
                            r_path_open <= 1'b1;
                        end
                        r_state <= S_ZMUL;
                    end
                end
                S_ZMUL: begin
                    r_after <= S_ZCAP;
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (mul_rsp.done) begin
                        r_state <= r_after;
                    end
                end
                S_ZCAP: begin
                    r_zprod <= mul_rsp.result[46:0];
                    r_path  <= 1'b0;
                    r_state <= S_XSET;
                end
                S_XSET: begin
                    // u = x/64 in Q8.56, magnitude and sign kept apart
                    r_neg   <= x_c[30];
                    r_mag   <= {11'd0, x_abs, 22'd0};
                    r_sum   <= ONE_Q56;
                    r_term  <= ONE_Q56;
                    r_k     <= 4'd1;
                    r_state <= S_TMUL;
                end
                S_TMUL: begin
                    r_after <= S_DIVS;
                    r_state <= S_MWAIT;
                end
                S_DIVS: begin
                    r_dvd   <= mul_rsp.result;
                    r_rem   <= 4'd0;
                    r_dcnt  <= 4'd0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // quotient nibbles shift in at the bottom
                    r_dvd  <= {r_dvd[59:0], d_q};
                    r_rem  <= d_rem;
                    r_dcnt <= r_dcnt + 4'd1;
                    if (r_dcnt == 4'd15) begin
                        r_state <= S_TACC;
                    end
                end
                S_TACC: begin
                    r_term <= r_dvd;
                    // odd terms subtract for a negative exponent
                    r_sum  <= (r_neg && r_k[0]) ? r_sum - r_dvd : r_sum + r_dvd;
                    if (r_k == TERMS) begin
                        r_sqc   <= 3'd0;
                        r_state <= S_SQ;
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_TMUL;
                    end
                end
                S_SQ: begin
                    r_after <= S_SQW;
                    r_state <= S_MWAIT;
                end
                S_SQW: begin
                    r_sum <= mul_rsp.result;
                    if (r_sqc == LAST_SQ) begin
                        r_state <= S_PMUL;
                    end else begin
                        r_sqc   <= r_sqc + 3'd1;
                        r_state <= S_SQ;
                    end
                end
                S_PMUL: begin
                    r_after <= S_PUPD;
                    r_state <= S_MWAIT;
                end
                S_PUPD: begin
                    if (!r_path) begin
                        r_price_p <= np;
                        if (crosses(np_clamp64, r_barrier, r_mode[1])) begin
                            r_crossed_p <= 1'b1;
                        end
                        r_path  <= 1'b1;
                        r_state <= S_XSET;
                    end else begin
                        r_price_m <= np;
                        if (crosses(np_clamp64, r_barrier, r_mode[1])) begin
                            r_crossed_m <= 1'b1;
                        end
                        r_state <= r_last ? S_PAY : S_IDLE;
                    end
                end
                S_PAY: begin
                    r_pay   <= pay32;
                    r_state <= S_PSQ;
                end
                S_PSQ: begin
                    r_after <= S_DONE;
                    r_state <= S_MWAIT;
                end
                S_DONE: begin
                    // wait for the output register to free up
                    if (!r_out_valid || i_out_ready) begin
                        r_psum      <= psum_n[64] ? '1 : psum_n[63:0];
                        r_qsum      <= qsum_n[64] ? '1 : qsum_n[63:0];
                        r_count     <= (r_count == '1) ? r_count : r_count + 32'd1;
                        r_path_open <= 1'b0;
                        r_out.path_payoff         <= r_pay;
                        r_out.payoff_total        <= psum_n[64] ? '1 : psum_n[63:0];
                        r_out.payoff_square_total <= qsum_n[64] ? '1 : qsum_n[63:0];
                        r_out.paths_done          <= (r_count == '1) ? r_count
                                                                     : r_count + 32'd1;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // divider remainder stays below the term index
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_k))
        else $error("divider remainder out of range");

    // path count never goes back
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count >= $past(r_count)))
        else $error("path count decreased");

    // crossing flags are sticky within an open path
    a_cross_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_path_open && $past(r_path_open)) |->
            (!$fell(r_crossed_p) && !$fell(r_crossed_m)))
        else $error("crossing flag cleared inside a path");

    // a result only comes out of the final state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the final state");

endmodule

`default_nettype wire
